[sv/bfpe_pkg.sv]
`default_nettype none
package bfpe_pkg;

   localparam int HASH_W  = 32;
   localparam int ROT_R   = 17;
   localparam int ROT_L   = 15;
   localparam int BITS_PB = 8;
   localparam int PC_W    = 6;
   localparam int BC_W    = 14;
   localparam int LEN_W   = 17;
   localparam int IDX_W   = 13;
   localparam int CSR_IW  = 2;
   localparam int CSR_DW  = 14;
   localparam int DIV_CW  = 5;

   localparam logic [CSR_IW-1:0] CSR_PROBE_COUNT = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_BYTE_COUNT  = 2'd1;

   localparam logic [PC_W-1:0] PROBE_COUNT_RST = 6'd6;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_QUERY  = 2'd1,
      FUNC_LOAD   = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef struct packed {
      func_type               func;
      logic [HASH_W-1:0]      key_hash;
      logic                   key_empty;
      logic [IDX_W-1:0]       byte_index;
      logic [BITS_PB-1:0]     byte_value;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [BITS_PB-1:0]     read_byte;
   } rsp_type;

endpackage
`default_nettype wire

[sv/bfpe_ram.sv]
`default_nettype none
module bfpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/bloom_filter_probe_engine.sv]
// insert/query: each probe is a 32-step shift-subtract remainder, one ram read, one
//   merge/write-back; result strobes the cycle after the last probe, a query stops early
//   on the first clear bit. load and empty key: result the cycle after accept; read byte:
//   S_BYTE after accept, then the registered result. a new item is taken in the cycle
//   its predecessor's result shows. reset is synchronous: control registers take their
//   defaults, the store is zeroed one byte a cycle, busy high; results cannot be stalled.
`default_nettype none
module bloom_filter_probe_engine #(
   parameter int MAX_BYTES  = 8192,
   parameter int MAX_PROBES = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire bfpe_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   output bfpe_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bfpe_pkg::CSR_IW-1:0]       csr_index,
   input  wire logic [bfpe_pkg::CSR_DW-1:0]       csr_wdata
);
   import bfpe_pkg::*;

   localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int PW = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
   localparam logic [BC_W-1:0] BYTE_COUNT_RST =
      (MAX_BYTES < 8192) ? BC_W'(MAX_BYTES) : BC_W'(8192);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CLEAR = 6'b000010,
      S_DIV   = 6'b000100,
      S_READ  = 6'b001000,
      S_MERGE = 6'b010000,
      S_BYTE  = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [PC_W-1:0]      probe_count_ff;
   logic [BC_W-1:0]      byte_count_ff;
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [DIV_CW-1:0]    div_cnt_ff, div_cnt_in;
   logic [PW-1:0]        probe_cnt_ff, probe_cnt_in;
   logic [PW-1:0]        last_ff, last_in;
   logic [HASH_W-1:0]    h_ff, h_in;
   logic [HASH_W-1:0]    delta_ff, delta_in;
   logic [HASH_W-1:0]    q_ff, q_in;
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   func_type             func_ff, func_in;
   logic                 idx_ok_ff, idx_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 idx_ok;
   logic [BC_W-1:0]      eff_bytes;
   logic [PC_W-1:0]      eff_probes;
   logic [LEN_W:0]       trial;
   logic [BITS_PB-1:0]   mask;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [BITS_PB-1:0]   mem_wdata, mem_rdata;

   bfpe_ram #(
      .WIDTH (BITS_PB),
      .DEPTH (MAX_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign idx_ok    = (32'(req_data.byte_index) < MAX_BYTES);

   always_comb begin
      if (byte_count_ff == '0) begin
         eff_bytes = BC_W'(1);
      end else if (32'(byte_count_ff) > MAX_BYTES) begin
         eff_bytes = BC_W'(MAX_BYTES);
      end else begin
         eff_bytes = byte_count_ff;
      end
      if (probe_count_ff == '0) begin
         eff_probes = PC_W'(1);
      end else if (32'(probe_count_ff) > MAX_PROBES) begin
         eff_probes = PC_W'(MAX_PROBES);
      end else begin
         eff_probes = probe_count_ff;
      end
   end

   assign trial = {rem_ff, q_ff[HASH_W-1]};
   assign mask  = BITS_PB'(1) << rem_ff[2:0];

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      probe_cnt_in = probe_cnt_ff;
      last_in      = last_ff;
      h_in         = h_ff;
      delta_in     = delta_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      func_in      = func_ff;
      idx_ok_in    = idx_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      mem_we       = 1'b0;
      mem_waddr    = AW'(req_data.byte_index);
      mem_wdata    = req_data.byte_value;
      mem_raddr    = AW'(req_data.byte_index);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in   = req_data.func;
               idx_ok_in = idx_ok;
               unique case (req_data.func) inside
                  FUNC_INSERT, FUNC_QUERY: begin
                     if (req_data.key_empty) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        h_in         = req_data.key_hash;
                        q_in         = req_data.key_hash;
                        delta_in     = (req_data.key_hash >> ROT_R) |
                                       (req_data.key_hash << ROT_L);
                        rem_in       = '0;
                        div_cnt_in   = '0;
                        probe_cnt_in = '0;
                        last_in      = PW'(eff_probes - PC_W'(1));
                        len_in       = {eff_bytes, 3'b000};
                        state_in     = S_DIV;
                     end
                  end
                  FUNC_LOAD: begin
                     mem_we       = idx_ok;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_READ: begin
                     state_in = S_BYTE;
                  end
                  default: ;
               endcase
            end
         end
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(MAX_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (trial >= {1'b0, len_ff}) begin
               rem_in = LEN_W'(trial - {1'b0, len_ff});
            end else begin
               rem_in = LEN_W'(trial);
            end
            q_in       = q_ff << 1;
            div_cnt_in = div_cnt_ff + DIV_CW'(1);
            if (div_cnt_ff == DIV_CW'(HASH_W - 1)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            mem_raddr = AW'(rem_ff >> 3);
            h_in      = h_ff + delta_ff;
            state_in  = S_MERGE;
         end
         S_MERGE: begin
            mem_waddr = AW'(rem_ff >> 3);
            mem_wdata = mem_rdata | mask;
            mem_we    = (func_ff == FUNC_INSERT);
            if ((func_ff == FUNC_QUERY) && ((mem_rdata & mask) == '0)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (probe_cnt_ff == last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.found = (func_ff == FUNC_QUERY);
               state_in     = S_IDLE;
            end else begin
               probe_cnt_in = probe_cnt_ff + PW'(1);
               q_in         = h_ff;
               rem_in       = '0;
               div_cnt_in   = '0;
               state_in     = S_DIV;
            end
         end
         S_BYTE: begin
            rsp_valid_in     = 1'b1;
            rsp_in.read_byte = idx_ok_ff ? mem_rdata : '0;
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         probe_count_ff <= PROBE_COUNT_RST;
         byte_count_ff  <= BYTE_COUNT_RST;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PROBE_COUNT) begin
               probe_count_ff <= PC_W'(csr_wdata);
            end else if (csr_index == CSR_BYTE_COUNT) begin
               byte_count_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      div_cnt_ff   <= div_cnt_in;
      probe_cnt_ff <= probe_cnt_in;
      last_ff      <= last_in;
      h_ff         <= h_in;
      delta_ff     <= delta_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      len_ff       <= len_in;
      func_ff      <= func_in;
      idx_ok_ff    <= idx_ok_in;
      rsp_ff       <= rsp_in;
   end

`ifndef SYNTHESIS
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.func == FUNC_LOAD)) |=> rsp_valid)
      else $error("load beat without result");

   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.func == FUNC_READ)) |-> ##2 rsp_valid)
      else $error("read beat without result");

   a_no_write_in_div: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == S_IDLE) || (state_ff == S_CLEAR) || (state_ff == S_MERGE)))
      else $error("store written outside a write state");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import bfpe_pkg::*;

   localparam int MAX_BYTES   = 8192;
   localparam int MAX_PROBES  = 32;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int IDLE_PCT    = 27;
   localparam int N_DIR       = 25;
   localparam int N_PHASE     = 9;

   typedef struct packed {
      req_type req;
      logic    chk;
      rsp_type want;
   } dir_row_type;

   localparam dir_row_type DIR_TAB [N_DIR] = '{
      '{'{FUNC_READ,   32'h0000_0000, 1'b0, 13'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_READ,   32'h0000_0000, 1'b0, 13'h1FFF, 8'h00}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_QUERY,  32'h0000_0000, 1'b0, 13'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_QUERY,  32'hFFFF_FFFF, 1'b0, 13'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_INSERT, 32'h0000_0000, 1'b0, 13'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_QUERY,  32'h0000_0000, 1'b0, 13'h0000, 8'h00}, 1'b0, '{1'b0, 8'h00}},
      '{'{FUNC_INSERT, 32'hDEAD_BEEF, 1'b1, 13'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_QUERY,  32'hDEAD_BEEF, 1'b1, 13'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_QUERY,  32'hDEAD_BEEF, 1'b0, 13'h0000, 8'h00}, 1'b0, '{1'b0, 8'h00}},
      '{'{FUNC_INSERT, 32'hDEAD_BEEF, 1'b0, 13'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_QUERY,  32'hDEAD_BEEF, 1'b0, 13'h0000, 8'h00}, 1'b0, '{1'b0, 8'h00}},
      '{'{FUNC_LOAD,   32'h0000_0000, 1'b0, 13'h1FFF, 8'hFF}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_READ,   32'h0000_0000, 1'b0, 13'h1FFF, 8'h00}, 1'b1, '{1'b0, 8'hFF}},
      '{'{FUNC_READ,   32'h0000_0000, 1'b0, 13'h0000, 8'h00}, 1'b0, '{1'b0, 8'h00}},
      '{'{FUNC_LOAD,   32'hFFFF_FFFF, 1'b1, 13'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_QUERY,  32'h0000_0000, 1'b0, 13'h0000, 8'h00}, 1'b0, '{1'b0, 8'h00}},
      '{'{FUNC_INSERT, 32'hFFFF_FFFF, 1'b0, 13'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_QUERY,  32'hFFFF_FFFF, 1'b0, 13'h0000, 8'h00}, 1'b0, '{1'b0, 8'h00}},
      '{'{FUNC_INSERT, 32'h8000_0000, 1'b0, 13'h0000, 8'h00}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_QUERY,  32'h8000_0000, 1'b0, 13'h0000, 8'h00}, 1'b0, '{1'b0, 8'h00}},
      '{'{FUNC_LOAD,   32'h0000_0000, 1'b0, 13'h1555, 8'h5A}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_READ,   32'hAAAA_5555, 1'b1, 13'h1555, 8'h00}, 1'b1, '{1'b0, 8'h5A}},
      '{'{FUNC_LOAD,   32'h0000_0000, 1'b0, 13'h0AAA, 8'hA5}, 1'b1, '{1'b0, 8'h00}},
      '{'{FUNC_READ,   32'h0000_0000, 1'b0, 13'h0AAA, 8'h00}, 1'b1, '{1'b0, 8'hA5}},
      '{'{FUNC_QUERY,  32'h0000_0001, 1'b0, 13'h0000, 8'h00}, 1'b0, '{1'b0, 8'h00}}
   };

   // raw register writes per phase; out-of-range values exercise the clamps and masks
   localparam logic [CSR_DW-1:0] PH_PROBE [N_PHASE] = '{
      14'd1, 14'd0, 14'd32, 14'h3FFF, 14'h3FC2, 14'd3, 14'd4, 14'd5, 14'd6
   };
   localparam logic [CSR_DW-1:0] PH_BYTES [N_PHASE] = '{
      14'd1, 14'd0, 14'd8192, 14'h3FFF, 14'd3, 14'd100, 14'd5000, 14'd8191, 14'd17
   };
   localparam int PH_ITEMS [N_PHASE] = '{60, 40, 16, 12, 80, 80, 70, 60, 107};
   localparam int PH_IDLE  [N_PHASE] = '{27, 27, 27, 27, 0, 27, 27, 27, 27};

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [CSR_IW-1:0]   csr_index;
   logic [CSR_DW-1:0]   csr_wdata;

   logic [7:0]          filter_mem [MAX_BYTES];
   logic [PC_W-1:0]     probe_reg;
   logic [BC_W-1:0]     bytes_reg;
   rsp_type             pending_rsp [$];
   logic [HASH_W-1:0]   inserted_keys [$];
   int                  mismatches = 0;
   int                  cycles = 0;
   int                  idle_pct;

   bloom_filter_probe_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_probes();
      int n;
      n = probe_reg;
      if (n < 1) n = 1;
      if (n > MAX_PROBES) n = MAX_PROBES;
      return n;
   endfunction

   function automatic int eff_bytes();
      int n;
      n = bytes_reg;
      if (n < 1) n = 1;
      if (n > MAX_BYTES) n = MAX_BYTES;
      return n;
   endfunction

   function automatic rsp_type bloom_apply(input req_type r);
      rsp_type           o;
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] step;
      logic [HASH_W-1:0] len;
      logic [HASH_W-1:0] pos;
      logic              hit;
      o = '0;
      hit = 1'b1;
      h = r.key_hash;
      step = (h >> ROT_R) | (h << ROT_L);
      len = 32'(eff_bytes() * BITS_PB);
      case (r.func) inside
         FUNC_INSERT, FUNC_QUERY: begin
            if (!r.key_empty) begin
               for (int i = 0; i < eff_probes(); i++) begin
                  pos = h % len;
                  if (r.func == FUNC_INSERT) filter_mem[pos[15:3]][pos[2:0]] = 1'b1;
                  else if (!filter_mem[pos[15:3]][pos[2:0]]) hit = 1'b0;
                  h = h + step;
               end
               o.found = (r.func == FUNC_QUERY) && hit;
            end
         end
         FUNC_LOAD: begin
            filter_mem[r.byte_index] = r.byte_value;
         end
         default: begin
            o.read_byte = filter_mem[r.byte_index];
         end
      endcase
      return o;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      sel;
      r.key_hash = $urandom;
      r.key_empty = ($urandom_range(9) == 0);
      r.byte_index = 13'($urandom);
      r.byte_value = 8'($urandom);
      if ($urandom_range(19) == 0) r.key_hash = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      sel = $urandom_range(99);
      if (sel < 30) begin
         r.func = FUNC_INSERT;
         if (!r.key_empty) inserted_keys.push_back(r.key_hash);
      end else if (sel < 65) begin
         r.func = FUNC_QUERY;
         // half the queries look up keys already inserted in this phase
         if (inserted_keys.size() != 0 && $urandom_range(1))
            r.key_hash = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      end else if (sel < 80) begin
         r.func = FUNC_LOAD;
      end else begin
         r.func = FUNC_READ;
      end
      if ((r.func == FUNC_LOAD || r.func == FUNC_READ) && $urandom_range(3) != 0)
         r.byte_index = 13'($urandom_range(eff_bytes() - 1));
      return r;
   endfunction

   task automatic issue(input req_type r, input logic use_want, input rsp_type want);
      rsp_type pred;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pred = bloom_apply(r);
      pending_rsp.push_back(use_want ? want : pred);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_PROBE_COUNT) probe_reg = val[PC_W-1:0];
      else if (idx == CSR_BYTE_COUNT) bytes_reg = val;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: found=%0b read_byte=%02h",
                        rsp_data.found, rsp_data.read_byte);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.found !== want.found || rsp_data.read_byte !== want.read_byte) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected found=%0b read_byte=%02h, %s",
                           want.found, want.read_byte,
                           $sformatf("got found=%0b read_byte=%02h",
                                     rsp_data.found, rsp_data.read_byte));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      probe_reg = PROBE_COUNT_RST;
      bytes_reg = 14'(MAX_BYTES);
      foreach (filter_mem[i]) filter_mem[i] = 8'h00;
      idle_pct = IDLE_PCT;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (DIR_TAB[i]) issue(DIR_TAB[i].req, DIR_TAB[i].chk, DIR_TAB[i].want);
      drain();
      for (int p = 0; p < N_PHASE; p++) begin
         csr_write(CSR_PROBE_COUNT, PH_PROBE[p]);
         csr_write(CSR_BYTE_COUNT, PH_BYTES[p]);
         csr_valid <= 1'b0;
         idle_pct = PH_IDLE[p];
         inserted_keys.delete();
         repeat (PH_ITEMS[p]) issue(random_req(), 1'b0, '0);
         drain();
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/bfpe_pkg.sv
sv/bfpe_ram.sv
sv/bloom_filter_probe_engine.sv
tb/tb_top.sv
